/* rtl/core/prrcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package prrcs_pkg;

  // Operation codes of an input transaction.
  localparam logic [2:0] OP_RESERVE = 3'd0;
  localparam logic [2:0] OP_COMMIT  = 3'd1;
  localparam logic [2:0] OP_FLUSH   = 3'd2;
  localparam logic [2:0] OP_PEEK    = 3'd3;
  localparam logic [2:0] OP_ADVANCE = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOTDONE = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_USABLE    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] grant_offset;
    logic [10:0] segment_bytes;
    logic [15:0] first_number;
    logic [8:0]  entry_count;
    logic [14:0] fill_level;
    logic        ready_to_send;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/packet_ring_reserve_commit_segmenter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  op, packet_bytes, entry_offset, flush_request
// out      output     out_valid/out_ready status .. ready_to_send
// cfg      input      cfg_we             cfg_index, cfg_data
// Reserve, commit, flush, advance, clear and a peek that returns at once go through S_EXEC
// and S_OUT after acceptance before out_valid is raised.
// A peek that finds an uncommitted tail goes through S_EXEC, S_RD and S_OUT. A peek that
// builds a segment goes through S_EXEC, S_RD, an S_WALK and S_STEP pair per further joined
// entry, a final S_WALK or a rejecting S_STEP, and S_OUT; it reads the metadata memory (registered read data).
// Reset is synchronous and clears all bookkeeping; the metadata memory is not cleared.
// A pending result holds the unit until it is taken; in_ready is low meanwhile.
module packet_ring_reserve_commit_segmenter_unit #(
  parameter int ALIGN_BYTES       = 4,
  parameter int HEADER_BYTES      = 4,
  parameter int MAX_PACKET_BYTES  = 252,
  parameter int MAX_SEGMENT_BYTES = 1024,
  parameter int RING_BYTES        = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_packet_bytes,
  input  wire logic [13:0] in_entry_offset,
  input  wire logic        in_flush_request,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [13:0]      out_grant_offset,
  output logic [10:0]      out_segment_bytes,
  output logic [15:0]      out_first_number,
  output logic [8:0]       out_entry_count,
  output logic [14:0]      out_fill_level,
  output logic             out_ready_to_send,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int META_DEPTH = (RING_BYTES + MAX_PACKET_BYTES + HEADER_BYTES) / ALIGN_BYTES;
  localparam int AW = $clog2(META_DEPTH);
  localparam int LW = 11;
  localparam logic [18:0] MAXP = 19'(MAX_PACKET_BYTES);
  localparam logic [18:0] MAXS = 19'(MAX_SEGMENT_BYTES);
  localparam logic [18:0] RINGB = 19'(RING_BYTES);
  localparam logic [18:0] ALGN = 19'(ALIGN_BYTES);
  localparam logic [18:0] HDR = 19'(HEADER_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r;
  logic [2:0]  op_r;
  logic [7:0]  pkt_r;
  logic [13:0] eoff_r;
  logic        freq_r;
  logic [14:0] usable_r, thresh_r;
  logic [18:0] head_r, tail_r, level_r, pend_r, size_r;
  logic [15:0] pcnt_r, ovr_r, sfirst_r;
  logic [8:0]  scount_r;
  logic        flush_r;
  logic [18:0] len_r, step_r, off_r;
  logic [8:0]  n_r;
  prrcs_pkg::result_t res_r;

  // Metadata memory: bit LW is the committed flag, the rest the aligned length.
  logic [LW:0] mem [META_DEPTH];
  logic [LW:0] rdata_r;
  logic        mwe;
  logic [AW-1:0] waddr, raddr;
  logic [LW:0] wdata;
  logic [18:0] ridx_full, widx_full;

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Clamped usable size, aligned down.
  logic [18:0] usize;
  always_comb begin
    usize = {4'd0, usable_r};
    if (usize < 19'd256) usize = 19'd256;
    if (usize > RINGB) usize = RINGB;
    usize = (usize / ALGN) * ALGN;
  end

  logic [18:0] pk, rlen, room;
  always_comb begin
    pk = {11'd0, pkt_r};
    if (pk > MAXP) pk = MAXP;
    rlen = ((pk + HDR + ALGN - 19'd1) / ALGN) * ALGN;
    room = (level_r >= size_r) ? 19'd0 : size_r - level_r;
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  // Memory address selection for the shared port; the walk reads the next entry ahead.
  always_comb begin
    mwe = 1'b0;
    wdata = rdata_r;
    widx_full = head_r / ALGN;
    ridx_full = (state_r == S_WALK) ? (off_r + step_r) / ALGN : tail_r / ALGN;
    if (state_r == S_EXEC && op_r == prrcs_pkg::OP_RESERVE && room >= rlen) begin
      mwe = widx_full < 19'(META_DEPTH);
      wdata = {1'b0, rlen[LW-1:0]};
    end else if (state_r == S_OUT && op_r == prrcs_pkg::OP_COMMIT) begin
      widx_full = {5'd0, eoff_r} / ALGN;
      mwe = widx_full < 19'(META_DEPTH);
      wdata = {1'b1, rdata_r[LW-1:0]};
    end
    if (state_r == S_EXEC && op_r == prrcs_pkg::OP_COMMIT) begin
      ridx_full = {5'd0, eoff_r} / ALGN;
    end
    waddr = widx_full[AW-1:0];
    raddr = ridx_full[AW-1:0];
  end

  logic ridx_ok;
  logic ridx_ok_r;
  assign ridx_ok = ridx_full < 19'(META_DEPTH);

  always_ff @(posedge clk) begin
    ridx_ok_r <= ridx_ok;
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      usable_r <= 15'd16384;
      thresh_r <= 15'd1280;
      size_r <= RINGB;
      head_r <= '0; tail_r <= '0; level_r <= '0; pend_r <= '0;
      pcnt_r <= '0; ovr_r <= '0; flush_r <= 1'b0; sfirst_r <= '0; scount_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == prrcs_pkg::CFG_USABLE) begin
          usable_r <= cfg_data;
          head_r <= '0; tail_r <= '0; level_r <= '0; pend_r <= '0;
          sfirst_r <= '0; scount_r <= '0;
        end else begin
          thresh_r <= cfg_data;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= in_op; pkt_r <= in_packet_bytes;
            eoff_r <= in_entry_offset; freq_r <= in_flush_request;
            size_r <= usize;
            res_r <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          case (op_r)
            prrcs_pkg::OP_RESERVE: begin
              if (room >= rlen) begin
                res_r.grant_offset <= head_r[13:0];
                head_r <= (head_r + rlen >= size_r) ? head_r + rlen - size_r : head_r + rlen;
                level_r <= level_r + rlen;
              end else begin
                ovr_r <= ovr_r + 16'd1;
                res_r.status <= prrcs_pkg::ST_FULL;
              end
            end
            prrcs_pkg::OP_COMMIT: begin
              if (freq_r) flush_r <= 1'b1;
            end
            prrcs_pkg::OP_FLUSH: flush_r <= 1'b1;
            prrcs_pkg::OP_PEEK: begin
              if (level_r == 19'd0) begin
                res_r.status <= prrcs_pkg::ST_EMPTY;
              end else if (pend_r != 19'd0) begin
                res_r.grant_offset <= tail_r[13:0];
                res_r.segment_bytes <= pend_r[10:0];
                res_r.first_number <= sfirst_r;
                res_r.entry_count <= scount_r;
              end else begin
                state_r <= S_RD;
              end
            end
            prrcs_pkg::OP_ADVANCE: begin
              if (pend_r != 19'd0) begin
                tail_r <= (tail_r + pend_r >= size_r) ? tail_r + pend_r - size_r
                                                      : tail_r + pend_r;
                level_r <= (pend_r >= level_r) ? 19'd0 : level_r - pend_r;
                pend_r <= '0;
                flush_r <= 1'b0;
              end
            end
            prrcs_pkg::OP_CLEAR: begin
              head_r <= '0; tail_r <= '0; level_r <= '0; pend_r <= '0;
              sfirst_r <= '0; scount_r <= '0; ovr_r <= '0;
            end
            default: ;
          endcase
        end
        // First entry at the tail has been read.
        S_RD: begin
          if (!ridx_ok_r || !rdata_r[LW]) begin
            res_r.status <= prrcs_pkg::ST_NOTDONE;
            state_r <= S_OUT;
          end else begin
            len_r <= {8'd0, rdata_r[LW-1:0]};
            step_r <= {8'd0, rdata_r[LW-1:0]};
            off_r <= tail_r;
            n_r <= 9'd1;
            sfirst_r <= pcnt_r + ovr_r;
            pcnt_r <= pcnt_r + ovr_r + 16'd1;
            ovr_r <= '0;
            state_r <= S_WALK;
          end
        end
        // Advance to the next entry; its read is issued in this cycle.
        S_WALK: begin
          if (len_r >= level_r || off_r + step_r >= size_r) begin
            state_r <= S_OUT;
          end else begin
            off_r <= off_r + step_r;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (ridx_ok_r && rdata_r[LW] &&
              len_r + {8'd0, rdata_r[LW-1:0]} <= MAXS) begin
            len_r <= len_r + {8'd0, rdata_r[LW-1:0]};
            step_r <= {8'd0, rdata_r[LW-1:0]};
            n_r <= n_r + 9'd1;
            pcnt_r <= pcnt_r + 16'd1;
            state_r <= S_WALK;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (op_r == prrcs_pkg::OP_PEEK && res_r.status == prrcs_pkg::ST_OK &&
              pend_r == 19'd0 && level_r != 19'd0) begin
            pend_r <= len_r;
            scount_r <= n_r;
            res_r.grant_offset <= tail_r[13:0];
            res_r.segment_bytes <= len_r[10:0];
            res_r.first_number <= sfirst_r;
            res_r.entry_count <= n_r;
          end
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status        = res_r.status;
  assign out_grant_offset  = res_r.grant_offset;
  assign out_segment_bytes = res_r.segment_bytes;
  assign out_first_number  = res_r.first_number;
  assign out_entry_count   = res_r.entry_count;
  assign out_fill_level    = level_r[14:0];
  assign out_ready_to_send = (level_r != 19'd0) &&
                             (flush_r || level_r > {4'd0, thresh_r});

endmodule
`default_nettype wire

/* tb/sv/ring_segment_checker.sv */
`timescale 1ns / 1ps
module ring_segment_checker
  import prrcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_packet_bytes,
  input  logic [13:0] in_entry_offset,
  input  logic        in_flush_request,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int ALIGN = 4;
  localparam int HEADER = 4;
  localparam int MAX_PKT = 252;
  localparam int MAX_SEG = 1024;
  localparam int RING = 16384;
  localparam int META_ENTRIES = (RING + MAX_PKT + HEADER) / ALIGN;

  // Mirror of the ring bookkeeping.
  int unsigned usable_reg, threshold_reg;
  int unsigned head, tail, level, pend_len, seg_first, seg_count;
  logic [15:0] pkt_counter, overruns;
  logic        flush_flag;
  bit          entry_done [0:META_ENTRIES-1];
  int unsigned entry_len [0:META_ENTRIES-1];
  result_t     expected_results[$];

  assign pending = expected_results.size();

  function automatic int unsigned ring_span();
    int unsigned u;
    u = usable_reg;
    if (u < 256) u = 256;
    if (u > RING) u = RING;
    return (u / ALIGN) * ALIGN;
  endfunction

  function automatic void empty_ring();
    head = 0;
    tail = 0;
    level = 0;
    pend_len = 0;
    seg_first = 0;
    seg_count = 0;
  endfunction

  // Computes the result of one operation and updates the mirror.
  function automatic result_t predict_ring_op(logic [2:0] op, logic [7:0] pkt_in,
                                              logic [13:0] eoff, logic freq);
    result_t     r;
    int unsigned span, pkt, len, room, idx, step, off, n, elen;
    r = '0;
    span = ring_span();
    case (op)
      OP_RESERVE: begin
        pkt = (pkt_in > MAX_PKT) ? MAX_PKT : pkt_in;
        len = ((pkt + HEADER + ALIGN - 1) / ALIGN) * ALIGN;
        room = (level >= span) ? 0 : span - level;
        if (room >= len) begin
          idx = head / ALIGN;
          r.grant_offset = head[13:0];
          if (idx < META_ENTRIES) begin
            entry_done[idx] = 1'b0;
            entry_len[idx] = len;
          end
          head += len;
          if (head >= span) head -= span;
          level += len;
        end else begin
          overruns = overruns + 16'd1;
          r.status = ST_FULL;
        end
      end
      OP_COMMIT: begin
        idx = eoff / ALIGN;
        if (freq) flush_flag = 1'b1;
        if (idx < META_ENTRIES) entry_done[idx] = 1'b1;
      end
      OP_FLUSH: flush_flag = 1'b1;
      OP_PEEK: begin
        if (level == 0) begin
          r.status = ST_EMPTY;
        end else if (pend_len != 0) begin
          r.grant_offset = tail[13:0];
          r.segment_bytes = pend_len[10:0];
          r.first_number = seg_first[15:0];
          r.entry_count = seg_count[8:0];
        end else if (!entry_done[tail / ALIGN]) begin
          r.status = ST_NOTDONE;
        end else begin
          // Join committed entries from the tail until a stop condition.
          len = entry_len[tail / ALIGN];
          step = len;
          off = tail;
          n = 1;
          pkt_counter = pkt_counter + overruns;
          overruns = '0;
          seg_first = pkt_counter;
          pkt_counter = pkt_counter + 16'd1;
          forever begin
            if (len >= level) break;
            off += step;
            if (off >= span) break;
            if (!entry_done[off / ALIGN]) break;
            elen = entry_len[off / ALIGN];
            if (len + elen > MAX_SEG) break;
            len += elen;
            step = elen;
            n++;
            pkt_counter = pkt_counter + 16'd1;
          end
          pend_len = len;
          seg_count = n;
          r.grant_offset = tail[13:0];
          r.segment_bytes = len[10:0];
          r.first_number = seg_first[15:0];
          r.entry_count = n[8:0];
        end
      end
      OP_ADVANCE: begin
        if (pend_len != 0) begin
          tail += pend_len;
          if (tail >= span) tail -= span;
          level = (pend_len >= level) ? 0 : level - pend_len;
          pend_len = 0;
          flush_flag = 1'b0;
        end
      end
      OP_CLEAR: begin
        empty_ring();
        overruns = '0;
      end
      default: ;
    endcase
    r.fill_level = level[14:0];
    r.ready_to_send = (level != 0) && (flush_flag || level > threshold_reg);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      usable_reg = 16384;
      threshold_reg = 1280;
      empty_ring();
      pkt_counter = '0;
      overruns = '0;
      flush_flag = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Compare the result transaction against the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_result.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_result.status);
            fail_count++;
          end
          if (out_result.grant_offset !== exp_r.grant_offset) begin
            $error("grant_offset expected %0d actual %0d",
                   exp_r.grant_offset, out_result.grant_offset);
            fail_count++;
          end
          if (out_result.segment_bytes !== exp_r.segment_bytes) begin
            $error("segment_bytes expected %0d actual %0d",
                   exp_r.segment_bytes, out_result.segment_bytes);
            fail_count++;
          end
          if (out_result.first_number !== exp_r.first_number) begin
            $error("first_number expected %0d actual %0d",
                   exp_r.first_number, out_result.first_number);
            fail_count++;
          end
          if (out_result.entry_count !== exp_r.entry_count) begin
            $error("entry_count expected %0d actual %0d",
                   exp_r.entry_count, out_result.entry_count);
            fail_count++;
          end
          if (out_result.fill_level !== exp_r.fill_level) begin
            $error("fill_level expected %0d actual %0d",
                   exp_r.fill_level, out_result.fill_level);
            fail_count++;
          end
          if (out_result.ready_to_send !== exp_r.ready_to_send) begin
            $error("ready_to_send expected %0d actual %0d",
                   exp_r.ready_to_send, out_result.ready_to_send);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_ring_op(in_op, in_packet_bytes,
                                                   in_entry_offset, in_flush_request));
      // Register writes only happen while idle.
      if (cfg_we) begin
        if (cfg_index == CFG_USABLE) begin
          usable_reg = cfg_data;
          empty_ring();
        end else begin
          threshold_reg = cfg_data;
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import prrcs_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int META_ENTRIES = 4160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = OP_FLUSH;
  logic [7:0]  in_packet_bytes = '0;
  logic [13:0] in_entry_offset = '0;
  logic        in_flush_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_result;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_USABLE;
  logic [14:0] cfg_data = '0;
  int          fail_count, pending, idle_cycles;
  bit          calm;

  // Ring entries that have been granted, so commits never touch unwritten metadata.
  bit          entry_written [0:META_ENTRIES-1];
  int          written_list[$];
  int          open_grants[$];
  logic [2:0]  ops_in_flight[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  packet_ring_reserve_commit_segmenter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_packet_bytes(in_packet_bytes), .in_entry_offset(in_entry_offset),
    .in_flush_request(in_flush_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_result.status), .out_grant_offset(out_result.grant_offset),
    .out_segment_bytes(out_result.segment_bytes),
    .out_first_number(out_result.first_number),
    .out_entry_count(out_result.entry_count), .out_fill_level(out_result.fill_level),
    .out_ready_to_send(out_result.ready_to_send),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ring_segment_checker ring_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_packet_bytes(in_packet_bytes), .in_entry_offset(in_entry_offset),
    .in_flush_request(in_flush_request),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    int hold;
    hold = gap_length();
    out_ready = 1'b0;
    if (hold == 0) out_ready = 1'b1;
    else repeat (hold) @(negedge clk);
    out_ready = 1'b1;
  end

  // Track granted offsets and the watchdog on accepted transactions.
  always @(posedge clk) begin
    logic [2:0] op_done;
    int idx;
    if (rst_n) begin
      if (in_valid && in_ready) ops_in_flight.push_back(in_op);
      if (out_valid && out_ready && ops_in_flight.size() > 0) begin
        op_done = ops_in_flight.pop_front();
        if (op_done == OP_RESERVE && out_result.status == ST_OK) begin
          idx = out_result.grant_offset / 4;
          if (!entry_written[idx]) written_list.push_back(idx);
          entry_written[idx] = 1'b1;
          open_grants.push_back(out_result.grant_offset);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_op(logic [2:0] op, logic [7:0] pkt, logic [13:0] eoff, logic freq);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_packet_bytes = pkt;
    in_entry_offset = eoff;
    in_flush_request = freq;
    do @(posedge clk); while (!(in_valid && in_ready));
    gap = gap_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Commit a known-written entry, preferring the oldest open grant.
  task automatic send_commit();
    int off, pick;
    if (open_grants.size() > 0 && $urandom_range(0, 4) != 0) begin
      pick = (open_grants.size() > 1 && $urandom_range(0, 3) == 0) ? 1 : 0;
      off = open_grants[pick];
      open_grants.delete(pick);
    end else if (written_list.size() > 0) begin
      off = written_list[$urandom_range(0, written_list.size() - 1)] * 4;
    end else begin
      send_op(OP_FLUSH, 8'($urandom), 14'($urandom), 1'($urandom));
      return;
    end
    off = off + $urandom_range(0, 3);
    send_op(OP_COMMIT, 8'($urandom), off[13:0], $urandom_range(0, 9) == 0);
  endtask

  // Drop the input side first so an accepted transaction is never offered again.
  task automatic write_reg(logic idx, logic [14:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 36) begin
        r = $urandom_range(0, 9);
        send_op(OP_RESERVE, r < 7 ? 8'($urandom_range(0, 120)) : 8'($urandom),
                14'($urandom), 1'($urandom));
      end else if (r < 66) send_commit();
      else if (r < 79) send_op(OP_PEEK, 8'($urandom), 14'($urandom), 1'($urandom));
      else if (r < 93) send_op(OP_ADVANCE, 8'($urandom), 14'($urandom), 1'($urandom));
      else if (r < 95) send_op(OP_FLUSH, 8'($urandom), 14'($urandom), 1'($urandom));
      else if (r < 97) send_op(OP_CLEAR, 8'($urandom), 14'($urandom), 1'($urandom));
      else send_op(3'($urandom_range(6, 7)), 8'($urandom), 14'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    idle_cycles = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: saturation, not-yet-committed tail, repeated peek, empty queue.
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);
    send_op(OP_ADVANCE, 8'd0, 14'd0, 1'b0);
    send_op(OP_RESERVE, 8'd0, 14'd0, 1'b0);
    send_op(OP_RESERVE, 8'd255, 14'd0, 1'b0);
    send_op(OP_RESERVE, 8'd252, 14'd0, 1'b0);
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);
    send_op(OP_COMMIT, 8'd0, 14'd3, 1'b0);
    send_op(OP_COMMIT, 8'd0, 14'd4, 1'b1);
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);
    send_op(OP_ADVANCE, 8'd0, 14'd0, 1'b0);
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);
    send_op(3'd6, 8'hFF, 14'h3FFF, 1'b1);
    send_op(3'd7, 8'd0, 14'd0, 1'b0);
    send_op(OP_FLUSH, 8'd0, 14'd0, 1'b0);
    send_op(OP_CLEAR, 8'd0, 14'd0, 1'b0);
    send_op(OP_PEEK, 8'd0, 14'd0, 1'b0);

    // Smallest ring: overruns, wraps and counter skipping.
    write_reg(CFG_USABLE, 15'd0);
    write_reg(CFG_THRESHOLD, 15'd0);
    repeat (9) send_op(OP_RESERVE, 8'd60, 14'd0, 1'b0);
    random_phase(200);

    write_reg(CFG_USABLE, 15'd16384);
    write_reg(CFG_THRESHOLD, 15'h7FFF);
    calm = 1'b1;
    random_phase(250);
    calm = 1'b0;

    write_reg(CFG_USABLE, 15'h7FFF);
    write_reg(CFG_THRESHOLD, 15'd1280);
    random_phase(250);

    write_reg(CFG_USABLE, 15'd1023);
    write_reg(CFG_THRESHOLD, 15'($urandom_range(0, 1023)));
    random_phase(200);

    write_reg(CFG_USABLE, 15'd257);
    write_reg(CFG_THRESHOLD, 15'd16384);
    random_phase(230);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/prrcs_pkg.sv
rtl/core/packet_ring_reserve_commit_segmenter_unit.sv
tb/sv/ring_segment_checker.sv
tb/sv/tb_top.sv
